### rtl/core/vtrof_pkg.sv
// Shared constants and types for the vertical three-row OR filter.
// No dependencies; used by every module of the block but vtrof_ram.
package vtrof_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 1;
  localparam int PIX_W        = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    RES_CENTRE = 2'd0,
    RES_OR3    = 2'd1,
    RES_FLUSH  = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic             vld;
    res_kind_t        kind;
    logic             newest_b;
    logic             last;
    logic [PIX_W-1:0] px;
  } issue_t;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] wdata;
    logic             re;
  } ram_cmd_t;

endpackage

### rtl/core/vtrof_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module vtrof_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/vtrof_ctrl.sv
// Row/column sequencer: config registers, counters, line-memory commands.
// Depends on vtrof_pkg.
module vtrof_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vtrof_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [vtrof_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                accept,
  input  logic                                mode,
  input  logic [vtrof_pkg::PIX_W-1:0]         px,
  output vtrof_pkg::ram_cmd_t                 ram_cmd,
  output vtrof_pkg::issue_t                   issue,
  output logic                                flushing
);
  import vtrof_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic                    flush_r, flush_nxt;
  logic                    sel_r, sel_nxt;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic                    row_end;
  logic                    frame_end;
  logic                    pix_ok;

  always_comb begin
    if (width_r == '0) w_eff = WIDTH_REG_W'(1);
    else if (width_r > WIDTH_REG_W'(MAX_WIDTH)) w_eff = WIDTH_REG_W'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = HEIGHT_REG_W'(1);
    else if (height_r > HEIGHT_REG_W'(MAX_HEIGHT)) h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    else h_eff = height_r;
  end

  assign row_end   = (WIDTH_REG_W'(col_r) + WIDTH_REG_W'(1)) >= w_eff;
  assign frame_end = (HEIGHT_REG_W'(row_r) + HEIGHT_REG_W'(1)) >= h_eff;
  assign pix_ok    = accept && (mode == MODE_PIXEL) && !flush_r;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    sel_nxt   = sel_r;
    issue.vld      = 1'b0;
    issue.kind     = RES_CENTRE;
    issue.newest_b = sel_r;
    issue.last     = 1'b0;
    issue.px       = px;
    if (accept && mode == MODE_FLUSH && flush_r) begin
      issue.vld  = 1'b1;
      issue.kind = RES_FLUSH;
      issue.last = row_end;
      if (row_end) begin
        flush_nxt = 1'b0;
        col_nxt   = '0;
        row_nxt   = '0;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end else if (pix_ok) begin
      if (row_r == ROW_W'(1)) begin
        issue.vld  = 1'b1;
        issue.kind = RES_CENTRE;
      end else if (row_r >= ROW_W'(2)) begin
        issue.vld  = 1'b1;
        issue.kind = RES_OR3;
      end
      if (row_end) begin
        col_nxt = '0;
        sel_nxt = ~sel_r;
        if (frame_end) begin
          flush_nxt = 1'b1;
          row_nxt   = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // older row is overwritten with the incoming pixel; read-first RAM keeps
  // the above value for this item
  assign ram_cmd.we_a  = pix_ok && sel_r;
  assign ram_cmd.we_b  = pix_ok && !sel_r;
  assign ram_cmd.addr  = col_r;
  assign ram_cmd.wdata = px;
  assign ram_cmd.re    = accept;
  assign flushing      = flush_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      flush_r  <= 1'b0;
      sel_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == CFG_IMAGE_WIDTH) begin
        width_r <= cfg_wdata[WIDTH_REG_W-1:0];
      end
      if (cfg_we && cfg_addr == CFG_IMAGE_HEIGHT) begin
        height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      flush_r <= flush_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

### rtl/core/vtrof_merge.sv
// Read-data stage and output register: combines line-memory reads with the
// current pixel. Depends on vtrof_pkg.
module vtrof_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vtrof_pkg::issue_t           issue,
  input  logic [vtrof_pkg::PIX_W-1:0] rdata_a,
  input  logic [vtrof_pkg::PIX_W-1:0] rdata_b,
  output logic                        take_ok,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [vtrof_pkg::PIX_W-1:0] out_tdata,
  output logic                        out_tlast
);
  import vtrof_pkg::*;

  logic             s1_v_r;
  res_kind_t        s1_kind_r;
  logic             s1_newest_b_r;
  logic             s1_last_r;
  logic [PIX_W-1:0] s1_px_r;
  logic             s1_adv;
  logic [PIX_W-1:0] newest, older, res;
  logic             out_v_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  assign s1_adv  = s1_v_r && (!out_v_r || out_tready);
  assign take_ok = !s1_v_r || s1_adv;

  assign newest = s1_newest_b_r ? rdata_b : rdata_a;
  assign older  = s1_newest_b_r ? rdata_a : rdata_b;

  always_comb begin
    case (s1_kind_r)
      RES_CENTRE: res = newest;
      RES_OR3:    res = older | newest | s1_px_r;
      RES_FLUSH:  res = newest;
      default:    res = newest;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (issue.vld) s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (s1_adv) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
    if (issue.vld) begin
      s1_kind_r     <= issue.kind;
      s1_newest_b_r <= issue.newest_b;
      s1_last_r     <= issue.last;
      s1_px_r       <= issue.px;
    end
    if (s1_adv) begin
      out_data_r <= res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/core/vertical_three_row_or_filter_top.sv
// Top level of the vertical three-row OR filter.
// Depends on vtrof_pkg, vtrof_ctrl, vtrof_ram, vtrof_merge.
//
// Takes one BGR item per clock with no bubbles: each accepted pixel reads
// both line memories and overwrites the older row in the same cycle, so the
// rate is one item per cycle, limited by the one read and one write port of
// each line memory. The input stalls only while the read stage and the
// output register both hold results and out_tready is low. A result is
// registered in the read stage when its item is accepted, then moves into
// the output register when that register is empty or being drained.
// Results are one row behind the input; row 0 gives no result, and after
// the last row one flush tick (tuser high) per pixel drains the bottom
// row, the final one with tlast. No clearing pass.
module vertical_three_row_or_filter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vtrof_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [vtrof_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,   // blue, green, red
  input  logic                                in_tuser,   // mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // out_blue, out_green, out_red
  output logic                                out_tlast   // frame_end
);
  import vtrof_pkg::*;

  logic             accept;
  ram_cmd_t         ram_cmd;
  issue_t           issue;
  logic             flushing;
  logic [PIX_W-1:0] rdata_a, rdata_b;

  assign accept = in_tvalid && in_tready;

  vtrof_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .mode      (in_tuser),
    .px        (in_tdata),
    .ram_cmd   (ram_cmd),
    .issue     (issue),
    .flushing  (flushing)
  );

  vtrof_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_row_a (
    .clk   (clk),
    .we    (ram_cmd.we_a),
    .waddr (ram_cmd.addr),
    .wdata (ram_cmd.wdata),
    .re    (ram_cmd.re),
    .raddr (ram_cmd.addr),
    .rdata (rdata_a)
  );

  vtrof_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_row_b (
    .clk   (clk),
    .we    (ram_cmd.we_b),
    .waddr (ram_cmd.addr),
    .wdata (ram_cmd.wdata),
    .re    (ram_cmd.re),
    .raddr (ram_cmd.addr),
    .rdata (rdata_b)
  );

  vtrof_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b),
    .take_ok    (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_one_row_written: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_cmd.we_a && ram_cmd.we_b))
    else $error("both line memories written at once");

  a_write_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_cmd.we_a || ram_cmd.we_b) |-> (accept && !flushing))
    else $error("line memory written without an accepted pixel");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output can drain");

endmodule

### bench/vertical_three_row_or_filter_top_tb.sv
// Self-checking bench for vertical_three_row_or_filter_top: streams BGR frames
// and flush ticks, predicts the row-delayed 3x1 OR output and checks every item.
// Depends on vtrof_pkg and the RTL of the filter.
`timescale 1ns / 100ps

module vertical_three_row_or_filter_top_tb;
  import vtrof_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgr_t;

  typedef struct packed {
    logic mode;
    bgr_t px;
  } pix_item_t;

  typedef struct packed {
    logic frame_end;
    bgr_t px;
  } dil_px_t;

  localparam logic [23:0] EDGE_PX [8] = '{
    24'h000000, 24'hFFFFFF, 24'h0F0F0F, 24'hF0F0F0,
    24'h00FF00, 24'hFF00FF, 24'h808080, 24'h010101
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;    // blue, green, red
  logic                  in_tuser = 1'b0;  // mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;        // out_blue, out_green, out_red
  logic                  out_tlast;        // frame_end

  vertical_three_row_or_filter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending items and expected results
  pix_item_t pixel_q [$];
  dil_px_t   dil_q [$];
  int        err_cnt = 0;
  int        stim_cnt = 0;

  // predictor state
  logic [23:0]             line_a [MAX_WIDTH];
  logic [23:0]             line_b [MAX_WIDTH];
  int unsigned             col_cnt = 0;
  int unsigned             row_cnt = 0;
  bit                      flush_st = 1'b0;
  bit                      newest_b = 1'b0;
  logic [WIDTH_REG_W-1:0]  reg_width = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] reg_height = HEIGHT_RESET;

  int unsigned cyc = 0;
  logic        steady;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  pix_item_t   drv_item;
  dil_px_t     want;
  bgr_t        seen;

  always @(posedge clk) cyc <= cyc + 1;
  assign steady = (cyc >= 800 && cyc < 1800);

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
    return (v < 1) ? 1 : (v > maxv) ? maxv : v;
  endfunction

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic dilate_step(input pix_item_t it);
    int unsigned w, h, col;
    bit          row_end;
    logic [23:0] centre, above;
    dil_px_t     r;
    w = eff_dim(reg_width, MAX_WIDTH);
    h = eff_dim(reg_height, MAX_HEIGHT);
    col = col_cnt;
    row_end = (col + 1 >= w);
    if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
    centre = newest_b ? line_b[col] : line_a[col];
    above  = newest_b ? line_a[col] : line_b[col];
    if (it.mode == MODE_FLUSH) begin
      if (flush_st) begin
        r.px = centre;
        r.frame_end = row_end;
        dil_q.push_back(r);
        if (row_end) begin
          flush_st = 1'b0;
          col_cnt = 0;
          row_cnt = 0;
        end else begin
          col_cnt = col + 1;
        end
      end
    end else if (!flush_st) begin
      r.frame_end = 1'b0;
      if (row_cnt == 1) begin
        r.px = centre;
        dil_q.push_back(r);
      end else if (row_cnt >= 2) begin
        r.px = above | centre | it.px;
        dil_q.push_back(r);
      end
      if (newest_b) line_a[col] = it.px;
      else line_b[col] = it.px;
      if (row_end) begin
        col_cnt = 0;
        newest_b = !newest_b;
        if (row_cnt + 1 >= h) begin
          flush_st = 1'b1;
          row_cnt = 0;
        end else begin
          row_cnt = (row_cnt + 1) & 12'hFFF;
        end
      end else begin
        col_cnt = col + 1;
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) dilate_step({in_tuser, in_tdata});
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
          drv_item = pixel_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drv_item.mode;
          in_tdata  <= drv_item.px;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off once armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_armed && !hold_done && out_tvalid) begin
      hold_done  <= 1'b1;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 12);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata;
      if (dil_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected item %h last %b", out_tdata, out_tlast));
      end else begin
        want = dil_q.pop_front();
        if (seen.blue !== want.px.blue)
          flag_mismatch($sformatf("blue %h, want %h", seen.blue, want.px.blue));
        if (seen.green !== want.px.green)
          flag_mismatch($sformatf("green %h, want %h", seen.green, want.px.green));
        if (seen.red !== want.px.red)
          flag_mismatch($sformatf("red %h, want %h", seen.red, want.px.red));
        if (out_tlast !== want.frame_end)
          flag_mismatch($sformatf("frame_end %b, want %b", out_tlast, want.frame_end));
      end
    end
  end

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    reg_width = w[WIDTH_REG_W-1:0];
    @(posedge clk);
    cfg_addr  <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    reg_height = h[HEIGHT_REG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one frame plus its flush ticks; ignored flushes and pixels sprinkled in
  task automatic queue_frame(input int noise_pct, input bit directed);
    int        w, h, k;
    pix_item_t it;
    w = eff_dim(reg_width, MAX_WIDTH);
    h = eff_dim(reg_height, MAX_HEIGHT);
    for (k = 0; k < w * h; k++) begin
      if ((directed && k == 0) || $urandom_range(99) < noise_pct) begin
        it.mode = MODE_FLUSH;
        it.px = 24'($urandom);
        pixel_q.push_back(it);
      end
      it.mode = MODE_PIXEL;
      if (directed) it.px = EDGE_PX[k % 8];
      else if ($urandom_range(1)) it.px = 24'($urandom & $urandom & $urandom);
      else it.px = 24'($urandom);
      pixel_q.push_back(it);
    end
    for (k = 0; k < w; k++) begin
      if ((directed && k == 0) || $urandom_range(99) < noise_pct) begin
        it.mode = MODE_PIXEL;
        it.px = 24'($urandom);
        pixel_q.push_back(it);
      end
      it.mode = MODE_FLUSH;
      it.px = 24'($urandom);
      pixel_q.push_back(it);
    end
    stim_cnt += w * h + w;
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while ((pixel_q.size() != 0 || in_tvalid || dil_q.size() != 0) && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (dil_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", dil_q.size()));
      dil_q.delete();
    end
  endtask

  initial begin
    int gw, gh;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_geometry(13'd4, 13'd3);
    queue_frame(0, 1'b1);
    wait_idle();
    set_geometry(13'd1, 13'd1);
    queue_frame(0, 1'b1);
    wait_idle();
    set_geometry(13'd3, 13'd2);
    queue_frame(0, 1'b1);
    wait_idle();

    // width register truncation, zero values act as one
    set_geometry(13'h1802, 13'd3);
    queue_frame(2, 1'b0);
    wait_idle();
    set_geometry(13'd0, 13'd0);
    queue_frame(0, 1'b1);
    wait_idle();
    set_geometry(13'd40, 13'd6);
    hold_armed = 1'b1;
    queue_frame(2, 1'b0);
    wait_idle();

    while (stim_cnt < 1300) begin
      gw = ($urandom_range(7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
      gh = $urandom_range(1, 8);
      if (gw == 1 && $urandom_range(1)) gw = 0;
      if (gh == 1 && $urandom_range(1)) gh = 0;
      set_geometry(CFG_DATA_W'(gw), CFG_DATA_W'(gh));
      repeat ($urandom_range(1, 2)) queue_frame(4, 1'b0);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
